// File: hw/rtl/lagged_fibonacci_random_generator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lagged Fibonacci random generator
// Clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LAGGED_FIBONACCI_RANDOM_GENERATOR_TOP_MACROS_SVH
`define LAGGED_FIBONACCI_RANDOM_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define LFRG_ASSERT_IMPLIES(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define LFRG_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: hw/rtl/lfrg_pkg.sv
// ----------------------------------------------------------------------------
// lfrg_pkg
// Widths, constants and shared types of the lagged Fibonacci random generator.
// ----------------------------------------------------------------------------
package lfrg_pkg;

	localparam int unsigned WORD_W        = 24;
	localparam int unsigned VALUE_W       = 2 * WORD_W;
	localparam int unsigned COUNT_W       = 7;
	localparam int unsigned SEED_W        = 30;

	localparam int unsigned TABLE_DEPTH   = 97;
	localparam int unsigned LOW_LAG_START = 33;
	localparam int unsigned MAX_COUNT     = 64;

	// Fixed taps of the cell row: cell 0 holds the high-lag word, LOW_TAP the
	// low-lag word, ALT_TAP the low-lag word of the following step.
	localparam int unsigned LOW_TAP       = TABLE_DEPTH - LOW_LAG_START;
	localparam int unsigned ALT_TAP       = LOW_TAP + 1;

	localparam logic [WORD_W-1:0] CARRY_INIT  = 24'd362436;
	localparam logic [WORD_W-1:0] CD_CONST    = 24'd7654321;
	localparam logic [WORD_W-1:0] CM_CONST    = 24'd16777213;
	localparam logic [WORD_W-1:0] CARRY_RAISE = CM_CONST - CD_CONST;

	// Shift command for the cell row.
	typedef struct packed {
		logic down;
		logic up;
	} lfrg_shift_t;

	// Status of the seeding unit toward the top level.
	typedef struct packed {
		logic              word_valid;
		logic              done;
		logic [WORD_W-1:0] word;
	} lfrg_seed_status_t;

endpackage

// File: hw/rtl/lfrg_if.sv
// ----------------------------------------------------------------------------
// lfrg channel interfaces
// Valid/ready channels for the seed write, the request and the numbers.
// ----------------------------------------------------------------------------
interface lfrg_cfg_if import lfrg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SEED_W-1:0] seed;

	modport source (output valid, output seed, input ready);
	modport sink (input valid, input seed, output ready);
endinterface

interface lfrg_req_if import lfrg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] count;

	modport source (output valid, output count, input ready);
	modport sink (input valid, input count, output ready);
endinterface

interface lfrg_rsp_if import lfrg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic               last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

// File: hw/rtl/lfrg_cell.sv
// ----------------------------------------------------------------------------
// lfrg_cell
// One word of the lag table; takes its upper or lower neighbor on a shift.
// ----------------------------------------------------------------------------
module lfrg_cell import lfrg_pkg::*; (
	input  logic              clk,
	input  lfrg_shift_t       shift,
	input  logic [WORD_W-1:0] upper,
	input  logic [WORD_W-1:0] lower,
	output logic [WORD_W-1:0] word
);

	logic [WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		if (shift.down) begin
			word_q <= upper;
		end else if (shift.up) begin
			word_q <= lower;
		end
	end

	assign word = word_q;

endmodule

// File: hw/rtl/lfrg_seeder.sv
// ----------------------------------------------------------------------------
// lfrg_seeder
// Splits the seed with reciprocal multiplications in the SPLIT, LOW, QUOT
// and REM states, then runs the mod-179 and mod-169 generators to produce
// the table words, most significant bit first.
// ----------------------------------------------------------------------------
module lfrg_seeder import lfrg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SEED_W-1:0] seed,
	output lfrg_seed_status_t status
);

	localparam logic [SEED_W-1:0] SEED_LIMIT  = 30'd900000000;
	localparam int unsigned       DEN_W       = 15;
	localparam logic [DEN_W-1:0]  SEED_SPLIT  = 15'd30082;
	localparam logic [DEN_W-1:0]  HIGH_DIV    = 15'd177;
	localparam logic [DEN_W-1:0]  LOW_DIV     = 15'd169;
	// Half the seed times RECIP_SPLIT, shifted down by 43, is the seed over
	// 30082; exact for every 29-bit half.
	localparam logic [29:0]       RECIP_SPLIT = 30'd584807728;
	localparam logic [29:0]       RECIP_177   = 30'd23697;
	localparam logic [15:0]       MOD_179     = 16'd179;
	localparam logic [31:0]       RECIP_179   = 32'd46864;
	localparam logic [13:0]       MOD_169     = 14'd169;
	localparam logic [29:0]       RECIP_169   = 30'd24819;
	localparam logic [13:0]       LCG_MULT    = 14'd53;

	typedef enum logic [8:0] {
		SD_IDLE  = 9'b000000001,
		SD_SPLIT = 9'b000000010,
		SD_LOW   = 9'b000000100,
		SD_QUOT  = 9'b000001000,
		SD_REM   = 9'b000010000,
		SD_MUL1  = 9'b000100000,
		SD_MOD1  = 9'b001000000,
		SD_MUL2  = 9'b010000000,
		SD_MOD2  = 9'b100000000
	} sd_state_t;

	// Quotients by 177 and 169 of a 15-bit value; the estimate is exact over
	// the whole input range.
	function automatic logic [7:0] quot177(input logic [DEN_W-1:0] x);
		logic [29:0] prod;
		prod = 30'(x) * RECIP_177;
		return prod[29:22];
	endfunction

	function automatic logic [7:0] quot169(input logic [DEN_W-1:0] x);
		logic [29:0] prod;
		prod = 30'(x) * RECIP_169;
		return prod[29:22];
	endfunction

	// Remainder by 179 for products of two residues; the quotient estimate
	// is exact over this range, the final compare is a guard.
	function automatic logic [7:0] mod179(input logic [15:0] x);
		logic [31:0] prod;
		logic [7:0]  q;
		logic [15:0] r;
		prod = 32'(x) * RECIP_179;
		q    = prod[30:23];
		r    = x - 16'(q) * MOD_179;
		if (r >= MOD_179) begin
			r = r - MOD_179;
		end
		return r[7:0];
	endfunction

	function automatic logic [7:0] mod169(input logic [13:0] x);
		logic [29:0] prod;
		logic [6:0]  q;
		logic [13:0] r;
		prod = 30'(x) * RECIP_169;
		q    = prod[28:22];
		r    = x - 14'(q) * MOD_169;
		if (r >= MOD_169) begin
			r = r - MOD_169;
		end
		return r[7:0];
	endfunction

	sd_state_t         state_q;
	logic [SEED_W-1:0] seed_eff_q;
	logic [DEN_W-1:0]  hi_q;
	logic [DEN_W-1:0]  lo_q;
	logic [7:0]        hq_q;
	logic [7:0]        lq_q;
	logic [7:0]        first_q;
	logic [7:0]        second_q;
	logic [7:0]        third_q;
	logic [7:0]        lcg_q;
	logic [15:0]       prod_q;
	logic [13:0]       lprod_q;
	logic [7:0]        part_q;
	logic [4:0]        bit_cnt_q;
	logic [6:0]        word_cnt_q;
	logic [WORD_W-1:0] word_q;
	logic              word_valid_q;
	logic              done_q;

	logic [SEED_W-1:0] seed_eff;
	logic [58:0]       split_prod;
	logic [SEED_W-1:0] split_back;
	logic [7:0]        m_val;
	logic [11:0]       mix;

	// A zero or out-of-range seed runs as seed one.
	assign seed_eff = (seed == '0 || seed >= SEED_LIMIT) ? SEED_W'(1) : seed;

	// 30082 is twice 15041, so the high part comes from half the seed.
	assign split_prod = 59'(seed_eff_q[SEED_W-1:1]) * 59'(RECIP_SPLIT);
	assign split_back = SEED_W'(hi_q) * SEED_W'(SEED_SPLIT);

	assign m_val = mod179(prod_q);
	assign mix   = lcg_q[5:0] * m_val[5:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SD_IDLE;
			seed_eff_q   <= '0;
			hi_q         <= '0;
			lo_q         <= '0;
			hq_q         <= '0;
			lq_q         <= '0;
			first_q      <= '0;
			second_q     <= '0;
			third_q      <= '0;
			lcg_q        <= '0;
			prod_q       <= '0;
			lprod_q      <= '0;
			part_q       <= '0;
			bit_cnt_q    <= '0;
			word_cnt_q   <= '0;
			word_q       <= '0;
			word_valid_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			word_valid_q <= 1'b0;
			done_q       <= 1'b0;
			unique case (state_q)
				SD_IDLE: begin
					if (start) begin
						seed_eff_q <= seed_eff;
						word_cnt_q <= '0;
						bit_cnt_q  <= '0;
						state_q    <= SD_SPLIT;
					end
				end
				SD_SPLIT: begin
					hi_q    <= split_prod[57:43];
					state_q <= SD_LOW;
				end
				SD_LOW: begin
					lo_q    <= DEN_W'(seed_eff_q - split_back);
					hq_q    <= quot177(hi_q);
					state_q <= SD_QUOT;
				end
				SD_QUOT: begin
					// The high part stays below 177 * 177, so its quotient
					// needs no further reduction.
					first_q  <= hq_q + 8'd2;
					second_q <= 8'(hi_q - DEN_W'(hq_q) * HIGH_DIV) + 8'd2;
					lq_q     <= quot169(lo_q);
					state_q  <= SD_REM;
				end
				SD_REM: begin
					third_q <= lq_q + 8'd1;
					lcg_q   <= 8'(lo_q - DEN_W'(lq_q) * LOW_DIV);
					state_q <= SD_MUL1;
				end
				SD_MUL1: begin
					prod_q  <= 16'(first_q) * 16'(second_q);
					lprod_q <= 14'(lcg_q) * LCG_MULT + 14'd1;
					state_q <= SD_MOD1;
				end
				SD_MOD1: begin
					part_q  <= mod179(prod_q);
					lcg_q   <= mod169(lprod_q);
					state_q <= SD_MUL2;
				end
				SD_MUL2: begin
					prod_q  <= 16'(part_q) * 16'(third_q);
					state_q <= SD_MOD2;
				end
				SD_MOD2: begin
					first_q  <= second_q;
					second_q <= third_q;
					third_q  <= m_val;
					// The bit is set when the low six bits of the product reach 32.
					word_q   <= {word_q[WORD_W-2:0], mix[5]};
					state_q  <= SD_MUL1;
					if (bit_cnt_q == 5'(WORD_W - 1)) begin
						bit_cnt_q    <= '0;
						word_valid_q <= 1'b1;
						word_cnt_q   <= word_cnt_q + 7'd1;
						if (word_cnt_q == 7'(TABLE_DEPTH - 1)) begin
							done_q  <= 1'b1;
							state_q <= SD_IDLE;
						end
					end else begin
						bit_cnt_q <= bit_cnt_q + 5'd1;
					end
				end
				default: begin
					state_q <= SD_IDLE;
				end
			endcase
		end
	end

	assign status.word_valid = word_valid_q;
	assign status.done       = done_q;
	assign status.word       = word_q;

endmodule

// File: hw/rtl/lagged_fibonacci_random_generator_top.sv
// ----------------------------------------------------------------------------
// lagged_fibonacci_random_generator_top
// Universal lag-97/33 random generator with a subtractive carry sequence.
// cfg writes the 30-bit seed; a zero or out-of-range seed acts as one. req
// carries a count of numbers (above 64 is cut to 64, zero gives none); rsp
// returns 48-bit fractions in units of 2^-48, with last on the final one.
// The first request after reset or after a seed transfer seeds the table:
// the SPLIT, LOW, QUOT and REM states split the seed with reciprocal
// multiplies, then 97 words of 24 bits are made, each bit through the
// MUL1, MOD1, MUL2 and MOD2 generator states, before the unit reports done.
// After that every number is one shift of the 97-cell row; the first is
// registered once the state is run and the result register is free, and
// one follows every cycle while rsp.ready is high. When rsp stalls, the
// result register holds and the row stops. A new request transfer is taken
// as soon as the last number is loaded, even while it still waits. Reset
// sets the seed to one and marks the table unseeded; cfg is always ready.
// cfg is written only while idle by the user, not enforced by the block.
// ----------------------------------------------------------------------------
`include "lagged_fibonacci_random_generator_top_macros.svh"

module lagged_fibonacci_random_generator_top import lfrg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lfrg_cfg_if.sink   cfg,
	lfrg_req_if.sink   req,
	lfrg_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SEED = 3'b010,
		ST_RUN  = 3'b100
	} lfrg_state_t;

	lfrg_state_t        state_q;
	logic [SEED_W-1:0]  seed_q;
	logic               seeded_q;
	logic [WORD_W-1:0]  carry_q;
	logic [COUNT_W-1:0] remaining_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] value_q;
	logic               last_q;

	logic               accept;
	logic               seed_start;
	logic [COUNT_W-1:0] count_clamp;
	logic               step;
	logic [WORD_W-1:0]  new_word;
	logic [WORD_W-1:0]  carry_next;
	logic [WORD_W-1:0]  uni;
	logic [WORD_W-1:0]  alt;
	logic [VALUE_W-1:0] value_next;
	lfrg_shift_t        shift;
	lfrg_seed_status_t  seed_st;
	logic [WORD_W-1:0]  cell_word [TABLE_DEPTH];

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	assign count_clamp = (req.count > COUNT_W'(MAX_COUNT)) ? COUNT_W'(MAX_COUNT) : req.count;
	assign seed_start  = accept && !seeded_q;

	// While running, a number is made whenever the result register is free or being emptied.
	assign step = (state_q == ST_RUN) && (!out_valid_q || rsp.ready);

	// Cell 0 always holds the high-lag word and LOW_TAP the low-lag word, so
	// the lag pointers of the table become fixed taps of the shifting row.
	assign new_word   = cell_word[0] - cell_word[LOW_TAP];
	assign carry_next = (carry_q >= CD_CONST) ? carry_q - CD_CONST : carry_q + CARRY_RAISE;
	assign uni        = new_word - carry_next;

	// A zero number falls back to the next low-lag word, which sits one cell
	// above the low tap before the shift, and to the smallest fraction if
	// that word is zero as well.
	assign alt = cell_word[ALT_TAP];
	always_comb begin
		if (uni != '0) begin
			value_next = {uni, WORD_W'(0)};
		end else if (alt != '0) begin
			value_next = VALUE_W'(alt);
		end else begin
			value_next = VALUE_W'(1);
		end
	end

	// Running numbers shift the row down with the new word entering at the
	// top; seeding shifts it up so the first seeded word ends in the top cell.
	assign shift.down = step;
	assign shift.up   = seed_st.word_valid;

	lfrg_seeder u_seeder (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seed_start),
		.seed   (seed_q),
		.status (seed_st)
	);

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		logic [WORD_W-1:0] from_upper;
		logic [WORD_W-1:0] from_lower;

		if (k == TABLE_DEPTH - 1) begin : g_top
			assign from_upper = new_word;
		end else begin : g_mid_up
			assign from_upper = cell_word[k+1];
		end

		if (k == 0) begin : g_bottom
			assign from_lower = seed_st.word;
		end else begin : g_mid_dn
			assign from_lower = cell_word[k-1];
		end

		lfrg_cell u_cell (
			.clk   (clk),
			.shift (shift),
			.upper (from_upper),
			.lower (from_lower),
			.word  (cell_word[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= SEED_W'(1);
			seeded_q    <= 1'b0;
			carry_q     <= CARRY_INIT;
			remaining_q <= '0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			if (cfg.valid) begin
				seed_q   <= cfg.seed;
				seeded_q <= 1'b0;
			end

			if (step) begin
				out_valid_q <= 1'b1;
				value_q     <= value_next;
				last_q      <= (remaining_q == COUNT_W'(1));
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						remaining_q <= count_clamp;
						if (!seeded_q) begin
							state_q <= ST_SEED;
						end else if (count_clamp != '0) begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_SEED: begin
					if (seed_st.done) begin
						seeded_q <= 1'b1;
						carry_q  <= CARRY_INIT;
						state_q  <= (remaining_q != '0) ? ST_RUN : ST_IDLE;
					end
				end
				ST_RUN: begin
					if (step) begin
						carry_q     <= carry_next;
						remaining_q <= remaining_q - COUNT_W'(1);
						if (remaining_q == COUNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.value = value_q;
	assign rsp.last  = last_q;

	`LFRG_ASSERT_IMPLIES(a_step_seeded, step, seeded_q, "number made from an unseeded table")
	`LFRG_ASSERT_IMPLIES(a_seed_word_in_seed, seed_st.word_valid, state_q == ST_SEED, "seed word outside seeding")
	`LFRG_ASSERT_NEXT(a_last_ends_run, step && (remaining_q == COUNT_W'(1)), (state_q == ST_IDLE) && last_q, "final number did not end the request")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lagged Fibonacci random generator regression
// Random-length requests are sent through the valid/ready request channel under
// several seeds. A predictor inside the bench follows the lag-97/33 table and
// the carry sequence, and every returned number is checked against it in order.
// ----------------------------------------------------------------------------
module testbench;
	import lfrg_pkg::*;

	// Seeding arithmetic of the universal generator.
	localparam int unsigned SEED_SPLIT   = 30082;
	localparam int unsigned SEED_LIMIT   = 900000000;
	localparam int unsigned SEED_MAX     = (1 << SEED_W) - 1;
	localparam int unsigned THREE_LAG_M  = 179;
	localparam int unsigned FIRST_DIV    = 177;
	localparam int unsigned THIRD_MOD    = 178;
	localparam int unsigned LCG_M        = 169;
	localparam int unsigned LCG_MUL      = 53;

	// The seeding walk may still be running after the last number came out
	// when the last accepted request had a zero count.
	localparam int unsigned SEED_SETTLE  = 9600;
	localparam int unsigned QUIET_SETTLE = 4;
	localparam int unsigned END_SETTLE   = 40;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned SEGMENTS     = 5;
	localparam int unsigned SEGMENT_LEN  = 60;
	localparam int unsigned TAIL_LEN     = 50;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} number_t;

	logic clk = 1'b0;
	logic arst_n;

	lfrg_cfg_if cfg_bus();
	lfrg_req_if req_bus();
	lfrg_rsp_if rsp_bus();

	lagged_fibonacci_random_generator_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the generator state, advanced at each request transfer.
	logic [WORD_W-1:0]  lag_words [1:TABLE_DEPTH];
	int unsigned        high_ptr;
	int unsigned        low_ptr;
	logic [WORD_W-1:0]  carry;
	logic [SEED_W-1:0]  seed_shadow;
	bit                 table_ready;

	// Counts still to be offered, and numbers predicted but not yet returned.
	logic [COUNT_W-1:0] request_queue [$];
	number_t            owed_numbers [$];

	// Handshake bookkeeping shared between the stimulus and the two channel
	// processes. These are written with blocking assignments inside a single
	// process step, so a reader never sees a popped request that is not yet
	// marked as being offered.
	bit          offer_open;
	bit          quiet_tail;
	bit          calm_tail;
	int unsigned send_gap;
	int unsigned stall_left;
	int unsigned hold_left;
	int unsigned hold_requests;
	int unsigned hold_served;
	int unsigned results_seen;
	int unsigned mismatches;

	// Fill the 97-word table from the seed with the mod-179 three-lag
	// generator and the mod-169 congruential generator, 24 bits per word.
	task automatic fill_table();
		int unsigned s, hi, lo, i, j, k, l, m, n, b;
		logic [WORD_W-1:0] word;
		s = seed_shadow;
		// A zero seed or one past the legal range behaves as seed one.
		if (s < 1 || s >= SEED_LIMIT) begin
			s = 1;
		end
		hi = s / SEED_SPLIT;
		lo = s - SEED_SPLIT * hi;
		i = ((hi / FIRST_DIV) % FIRST_DIV) + 2;
		j = (hi % FIRST_DIV) + 2;
		k = ((lo / LCG_M) % THIRD_MOD) + 1;
		l = lo % LCG_M;
		for (n = 1; n <= TABLE_DEPTH; n++) begin
			word = '0;
			for (b = 0; b < WORD_W; b++) begin
				m = (((i * j) % THREE_LAG_M) * k) % THREE_LAG_M;
				i = j;
				j = k;
				k = m;
				l = (LCG_MUL * l + 1) % LCG_M;
				word = {word[WORD_W-2:0], logic'(((l * m) % 64) >= 32)};
			end
			lag_words[n] = word;
		end
		carry = CARRY_INIT;
		high_ptr = TABLE_DEPTH;
		low_ptr = LOW_LAG_START;
		table_ready = 1'b1;
	endtask

	// One number: lagged difference written back, carry stepped, carry removed.
	task automatic draw_number(output logic [VALUE_W-1:0] v);
		logic [WORD_W-1:0] diff, mixed;
		diff = lag_words[high_ptr] - lag_words[low_ptr];
		lag_words[high_ptr] = diff;
		high_ptr = (high_ptr == 1) ? TABLE_DEPTH : high_ptr - 1;
		low_ptr = (low_ptr == 1) ? TABLE_DEPTH : low_ptr - 1;
		if (carry >= CD_CONST) begin
			carry = carry - CD_CONST;
		end else begin
			carry = carry + (CM_CONST - CD_CONST);
		end
		mixed = diff - carry;
		if (mixed != '0) begin
			v = {mixed, {WORD_W{1'b0}}};
		end else if (lag_words[low_ptr] != '0) begin
			// A zero number falls back to the low-lag word, already advanced,
			// read as a count of 2^-48 units.
			v = {{WORD_W{1'b0}}, lag_words[low_ptr]};
		end else begin
			v = VALUE_W'(1);
		end
	endtask

	// Work out every number one request causes and queue them in order.
	task automatic roll_numbers(input logic [COUNT_W-1:0] count);
		int unsigned n, k;
		number_t num;
		// Seeding comes first even when the request asks for nothing.
		if (!table_ready) begin
			fill_table();
		end
		n = (count > MAX_COUNT) ? MAX_COUNT : count;
		for (k = 0; k < n; k++) begin
			draw_number(num.value);
			num.last = (k == n - 1);
			owed_numbers.push_back(num);
		end
	endtask

	// Request driver: predicts the numbers of each transfer, then offers
	// the next pending count unless a random gap is running.
	always @(posedge clk) begin : request_driver
		logic               next_valid;
		logic [COUNT_W-1:0] next_count;
		if (arst_n) begin
			next_valid = req_bus.valid;
			next_count = req_bus.count;
			if (req_bus.valid && req_bus.ready) begin
				roll_numbers(req_bus.count);
				quiet_tail = (req_bus.count == '0);
				offer_open = 1'b0;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (request_queue.size() != 0) begin
					next_count = request_queue.pop_front();
					next_valid = 1'b1;
					offer_open = 1'b1;
					// At random, a gap is placed ahead of the following request.
					if (!calm_tail && $urandom_range(0, 5) == 0) begin
						send_gap = $urandom_range(1, 13);
					end
				end
			end
			// One nonblocking update per edge, so a valid that stays high for a
			// back-to-back request never drops.
			req_bus.valid <= next_valid;
			req_bus.count <= next_count;
		end
	end

	// Number receiver: checks each transfer against the oldest prediction and
	// paces rsp.ready with random stalls and the occasional long hold-off.
	always @(posedge clk) begin : number_receiver
		number_t want;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				results_seen++;
				if (owed_numbers.size() == 0) begin
					$display("%0t ns: unexpected number, expected none, actual value %h last %b",
						$time, rsp_bus.value, rsp_bus.last);
					mismatches++;
				end else begin
					want = owed_numbers.pop_front();
					if (rsp_bus.value !== want.value) begin
						$display("%0t ns: value mismatch, expected %h, actual %h",
							$time, want.value, rsp_bus.value);
						mismatches++;
					end
					if (rsp_bus.last !== want.last) begin
						$display("%0t ns: last mismatch, expected %b, actual %b",
							$time, want.last, rsp_bus.last);
						mismatches++;
					end
				end
			end
			if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
				if (!calm_tail && $urandom_range(0, 7) == 0) begin
					stall_left = $urandom_range(1, 13);
				end
			end
		end
	end

	// Count mix: mostly short requests, some long ones, and a few zero and
	// oversized counts.
	function automatic logic [COUNT_W-1:0] pick_count();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return COUNT_W'($urandom_range(1, 4));
		end else if (r < 85) begin
			return COUNT_W'($urandom_range(5, 20));
		end else if (r < 93) begin
			return COUNT_W'($urandom_range(21, MAX_COUNT));
		end else if (r < 97) begin
			return '0;
		end
		return COUNT_W'($urandom_range(MAX_COUNT + 1, (1 << COUNT_W) - 1));
	endfunction

	// Wait until every request is taken and every predicted number returned,
	// then give a zero-count seeding walk time to finish.
	task automatic drain();
		while (request_queue.size() != 0 || offer_open || owed_numbers.size() != 0) begin
			@(posedge clk);
		end
		repeat (quiet_tail ? SEED_SETTLE : QUIET_SETTLE) @(posedge clk);
	endtask

	// Seed write, only with the block idle. It also forces a new seeding walk.
	task automatic write_seed(input logic [SEED_W-1:0] s);
		drain();
		cfg_bus.seed  <= s;
		cfg_bus.valid <= 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		seed_shadow = s;
		table_ready = 1'b0;
	endtask

	initial begin : stimulus
		int unsigned seg, n, seen_mark;
		logic [SEED_W-1:0] s;

		cfg_bus.valid = 1'b0;
		cfg_bus.seed  = '0;
		req_bus.valid = 1'b0;
		req_bus.count = '0;
		rsp_bus.ready = 1'b0;
		arst_n        = 1'b0;

		seed_shadow   = SEED_W'(1);
		table_ready   = 1'b0;
		high_ptr      = TABLE_DEPTH;
		low_ptr       = LOW_LAG_START;
		carry         = CARRY_INIT;
		offer_open    = 1'b0;
		quiet_tail    = 1'b0;
		calm_tail     = 1'b0;
		send_gap      = 0;
		stall_left    = 0;
		hold_left     = 0;
		hold_requests = 0;
		hold_served   = 0;
		results_seen  = 0;
		mismatches    = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The reset seed is used first, without any write: the
		// first request seeds the table. Single, full, oversized, all-ones and
		// zero counts follow.
		request_queue.push_back(COUNT_W'(1));
		request_queue.push_back(COUNT_W'(MAX_COUNT));
		request_queue.push_back(COUNT_W'(MAX_COUNT + 1));
		request_queue.push_back('1);
		request_queue.push_back('0);
		request_queue.push_back(COUNT_W'(2));

		// A zero seed acts as one. The first request after the write asks for
		// nothing, yet it must still seed, and the next one sees that table.
		write_seed('0);
		request_queue.push_back('0);
		request_queue.push_back(COUNT_W'(5));

		// Largest legal seed.
		write_seed(SEED_W'(SEED_LIMIT - 1));
		request_queue.push_back(COUNT_W'(MAX_COUNT));
		request_queue.push_back(COUNT_W'(1));

		// All seed bits set, far past the legal range, so it acts as one.
		write_seed('1);
		request_queue.push_back(COUNT_W'(7));

		// First seed past the legal range.
		write_seed(SEED_W'(SEED_LIMIT));
		request_queue.push_back(COUNT_W'(1));
		request_queue.push_back(COUNT_W'(3));

		// Seed exactly at the split point, so the low part is zero.
		write_seed(SEED_W'(SEED_SPLIT));
		request_queue.push_back(COUNT_W'(MAX_COUNT - 1));
		request_queue.push_back('0);
		request_queue.push_back(COUNT_W'(4));

		// Random part: one seed per segment, mostly legal, sometimes zero or
		// out of range.
		for (seg = 0; seg <= SEGMENTS; seg++) begin
			n = $urandom_range(0, 9);
			if (n == 0) begin
				s = '0;
			end else if (n == 1) begin
				s = SEED_W'($urandom_range(SEED_LIMIT, SEED_MAX));
			end else begin
				s = SEED_W'($urandom_range(1, SEED_LIMIT - 1));
			end
			write_seed(s);
			// The last segment runs with no idling on either side.
			if (seg == SEGMENTS) begin
				calm_tail = 1'b1;
			end
			seen_mark = results_seen;
			for (n = 0; n < ((seg == SEGMENTS) ? TAIL_LEN : SEGMENT_LEN); n++) begin
				request_queue.push_back(pick_count());
			end
			// Once numbers flow in the second segment, the receiver holds off
			// for a long stretch while requests keep coming, so the block fills
			// and stalls its request side.
			if (seg == 1) begin
				while (results_seen == seen_mark) begin
					@(posedge clk);
				end
				hold_requests++;
			end
		end

		// Wait for the last numbers and watch a while for any stray one.
		drain();
		repeat (END_SETTLE) @(posedge clk);
		if (mismatches == 0) begin
			$display("lagged_fibonacci_random_generator_top regression: pass");
		end else begin
			$display("lagged_fibonacci_random_generator_top regression: fail");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run including every seeding walk.
	initial begin : watchdog
		#5000000;
		$display("lagged_fibonacci_random_generator_top regression: fail");
		$finish;
	end

endmodule
